// File: src/smmc_pkg.sv
// ----------------------------------------------------------------------------
// smmc_pkg
// shared widths, codes, reset values and control structs of the sensor
// min/max calibrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smmc_pkg;

    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 16;
    localparam int PHASE_W    = 2;
    localparam int BASE_SUM_W = 24;
    localparam int BASE_CNT_W = 8;
    localparam int BASE_DIV_W = BASE_CNT_W + 1;
    localparam int DIV_STEPS  = BASE_SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int WIN_CNT_W  = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int QEST_W     = DATA_W + 3;
    localparam int REM_W      = PROD_W + 4;

    localparam logic [BASE_CNT_W-1:0] BASE_COUNT_RST  = 8'd50;
    localparam logic [DATA_W-1:0]     TOUCH_THR_RST   = 16'd2000;
    localparam logic [WIN_CNT_W-1:0]  WINDOW_RST      = 16'd750;
    localparam logic [DATA_W-1:0]     FULL_SCALE_RST  = 16'd3300;
    localparam logic [DATA_W-1:0]     SAT_MAX         = 16'hFFFF;

    typedef enum logic [PHASE_W-1:0] {
        PH_BASELINE = 2'd0,
        PH_WAIT     = 2'd1,
        PH_CAL      = 2'd2,
        PH_DONE     = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_COUNT = 2'd0,
        CFG_TOUCH_THR  = 2'd1,
        CFG_WINDOW     = 2'd2,
        CFG_FULL_SCALE = 2'd3
    } cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic load_sample;
        logic update;
        logic div_start;
        logic load_idle;
        logic conv_hi;
        logic mul;
        logic est;
        logic rem;
        logic fix;
        logic store_mv;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic base_hit;
        logic done_next;
        logic div_done;
        logic fix_ok;
    } dp_status_t;

endpackage

// File: src/smmc_divider.sv
// ----------------------------------------------------------------------------
// smmc_divider
// restoring divider for the idle level, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smmc_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [smmc_pkg::BASE_SUM_W-1:0]  dividend,
    input  logic [smmc_pkg::BASE_DIV_W-1:0]  divisor,
    output logic                             done,
    output logic [smmc_pkg::BASE_SUM_W-1:0]  quotient
);
    import smmc_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BASE_SUM_W-1:0] quo_reg, quo_next;
    logic [BASE_DIV_W-1:0] rem_reg, rem_next;
    logic [BASE_DIV_W-1:0] dsr_reg, dsr_next;
    logic [BASE_DIV_W:0]   shifted;
    logic                  ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[BASE_SUM_W-1]};
        ge        = shifted >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[BASE_SUM_W-2:0], ge};
            rem_next = ge ? BASE_DIV_W'(shifted - {1'b0, dsr_reg})
                          : shifted[BASE_DIV_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/smmc_datapath.sv
// ----------------------------------------------------------------------------
// smmc_datapath
// configuration registers, calibration state, millivolt conversion and
// result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smmc_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smmc_pkg::CFG_W-1:0]      cfg_data,
    input  logic [smmc_pkg::DATA_W-1:0]     sample,
    input  smmc_pkg::dp_cmd_t               cmd,
    output smmc_pkg::dp_status_t            status,
    output logic [smmc_pkg::PHASE_W-1:0]    phase,
    output logic [smmc_pkg::DATA_W-1:0]     idle_level,
    output logic [smmc_pkg::DATA_W-1:0]     low_value,
    output logic [smmc_pkg::DATA_W-1:0]     high_value,
    output logic [smmc_pkg::DATA_W-1:0]     value_range,
    output logic [smmc_pkg::DATA_W-1:0]     low_millivolts,
    output logic [smmc_pkg::DATA_W-1:0]     high_millivolts,
    output logic                            done_res
);
    import smmc_pkg::*;

    localparam logic [DATA_W-1:0] SAMPLE_MASK = DATA_W'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [REM_W-1:0] MODULUS = REM_W'((1 << SAMPLE_BITS) - 1);

    // configuration
    logic [BASE_CNT_W-1:0] base_count_reg;
    logic [DATA_W-1:0]     touch_thr_reg;
    logic [WIN_CNT_W-1:0]  window_reg;
    logic [DATA_W-1:0]     full_scale_reg;

    // calibration state
    logic [DATA_W-1:0]     sample_reg;
    phase_t                phase_reg, phase_next;
    logic [BASE_SUM_W-1:0] sum_reg, sum_next;
    logic [BASE_CNT_W-1:0] bcnt_reg, bcnt_next;
    logic [DATA_W-1:0]     idle_reg;
    logic [DATA_W-1:0]     min_reg, min_next;
    logic [DATA_W-1:0]     max_reg, max_next;
    logic [WIN_CNT_W-1:0]  wcnt_reg, wcnt_next;

    // conversion
    logic [PROD_W-1:0]        prod_reg;
    logic signed [QEST_W-1:0] qest_reg;
    logic signed [REM_W-1:0]  rem_reg;
    logic [DATA_W-1:0]        mv_lo_reg, mv_hi_reg;

    // result beat
    logic [PHASE_W-1:0] out_phase_reg;
    logic [DATA_W-1:0]  out_idle_reg, out_low_reg, out_high_reg, out_range_reg;
    logic [DATA_W-1:0]  out_mv_lo_reg, out_mv_hi_reg;
    logic               out_done_reg;

    logic                  base_hit, win_hit, touch;
    logic [DATA_W-1:0]     deviation;
    logic [BASE_DIV_W-1:0] base_divisor;
    logic                  div_done;
    logic [BASE_SUM_W-1:0] div_quotient;
    logic [DATA_W-1:0]     conv_value;
    logic [PROD_W-1:0]     prod_next;
    logic [PROD_W:0]       est_sum;
    logic signed [REM_W-1:0] qest_ext;
    logic                  rem_neg, rem_big;
    logic                  is_done;

    always_comb
    begin
        sum_next     = sum_reg + BASE_SUM_W'(sample_reg);
        bcnt_next    = bcnt_reg + 1'b1;
        base_hit     = (phase_reg == PH_BASELINE) && (bcnt_next == base_count_reg);
        base_divisor = (bcnt_next == '0) ? BASE_DIV_W'(1 << BASE_CNT_W)
                                         : {1'b0, bcnt_next};
        deviation    = (sample_reg >= idle_reg) ? (sample_reg - idle_reg)
                                                : (idle_reg - sample_reg);
        touch        = deviation >= touch_thr_reg;
        wcnt_next    = wcnt_reg + 1'b1;
        win_hit      = wcnt_next == window_reg;
        min_next     = (sample_reg < min_reg) ? sample_reg : min_reg;
        max_next     = (sample_reg > max_reg) ? sample_reg : max_reg;

        phase_next = phase_reg;
        case (phase_reg)
            PH_BASELINE: if (base_hit) phase_next = PH_WAIT;
            PH_WAIT:     if (touch)    phase_next = PH_CAL;
            PH_CAL:      if (win_hit)  phase_next = PH_DONE;
            default:     phase_next = phase_reg;
        endcase
    end

    smmc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_next),
        .divisor  (base_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // value * full scale / (2^n - 1): estimate from a shift-add reciprocal,
    // then step the quotient until the remainder lands in [0, 2^n - 1)
    always_comb
    begin
        conv_value = cmd.conv_hi ? max_reg : min_reg;
        prod_next  = conv_value * full_scale_reg;
        est_sum    = {1'b0, prod_reg} + (PROD_W + 1)'(prod_reg >> SAMPLE_BITS);
        qest_ext   = {{(REM_W - QEST_W){qest_reg[QEST_W-1]}}, qest_reg};
        rem_neg    = rem_reg[REM_W-1];
        rem_big    = !rem_neg && (rem_reg >= MODULUS);
        is_done    = phase_reg == PH_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_count_reg <= BASE_COUNT_RST;
            touch_thr_reg  <= TOUCH_THR_RST;
            window_reg     <= WINDOW_RST;
            full_scale_reg <= FULL_SCALE_RST;
            phase_reg      <= PH_BASELINE;
            sum_reg        <= '0;
            bcnt_reg       <= '0;
            idle_reg       <= '0;
            min_reg        <= SAMPLE_MASK;
            max_reg        <= '0;
            wcnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASE_COUNT: base_count_reg <= cfg_data[BASE_CNT_W-1:0];
                    CFG_TOUCH_THR:  touch_thr_reg  <= cfg_data;
                    CFG_WINDOW:     window_reg     <= cfg_data;
                    CFG_FULL_SCALE: full_scale_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.update)
            begin
                phase_reg <= phase_next;
                case (phase_reg)
                    PH_BASELINE:
                    begin
                        sum_reg  <= sum_next;
                        bcnt_reg <= bcnt_next;
                    end
                    PH_CAL:
                    begin
                        min_reg  <= min_next;
                        max_reg  <= max_next;
                        wcnt_reg <= wcnt_next;
                    end
                    default: ;
                endcase
            end
            if (cmd.load_idle)
                idle_reg <= (|div_quotient[BASE_SUM_W-1:DATA_W]) ? SAT_MAX
                                                                : div_quotient[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= sample & SAMPLE_MASK;
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.est)
            qest_reg <= QEST_W'(est_sum >> SAMPLE_BITS);
        if (cmd.rem)
            rem_reg <= REM_W'(prod_reg) - (qest_ext <<< SAMPLE_BITS) + qest_ext;
        if (cmd.fix)
        begin
            if (rem_neg)
            begin
                qest_reg <= qest_reg - 1'b1;
                rem_reg  <= rem_reg + MODULUS;
            end
            else if (rem_big)
            begin
                qest_reg <= qest_reg + 1'b1;
                rem_reg  <= rem_reg - MODULUS;
            end
        end
        if (cmd.store_mv)
        begin
            if (cmd.conv_hi)
                mv_hi_reg <= qest_reg[DATA_W-1:0];
            else
                mv_lo_reg <= qest_reg[DATA_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_phase_reg <= phase_reg;
            out_idle_reg  <= idle_reg;
            out_low_reg   <= min_reg;
            out_high_reg  <= max_reg;
            out_range_reg <= is_done ? (max_reg - min_reg) : '0;
            out_mv_lo_reg <= is_done ? mv_lo_reg : '0;
            out_mv_hi_reg <= is_done ? mv_hi_reg : '0;
            out_done_reg  <= is_done;
        end
    end

    assign status.base_hit  = base_hit;
    assign status.done_next = phase_next == PH_DONE;
    assign status.div_done  = div_done;
    assign status.fix_ok    = !rem_neg && !rem_big;

    assign phase           = out_phase_reg;
    assign idle_level      = out_idle_reg;
    assign low_value       = out_low_reg;
    assign high_value      = out_high_reg;
    assign value_range     = out_range_reg;
    assign low_millivolts  = out_mv_lo_reg;
    assign high_millivolts = out_mv_hi_reg;
    assign done_res        = out_done_reg;

endmodule

// File: src/smmc_ctrl.sv
// ----------------------------------------------------------------------------
// smmc_ctrl
// sequencer for one sample beat: update, idle division, millivolt
// conversion and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smmc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    output logic                  result_valid,
    input  logic                  result_stall,
    input  smmc_pkg::dp_status_t  status,
    output smmc_pkg::dp_cmd_t     cmd
);
    import smmc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UPDATE = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_EST    = 8'b0001_0000,
        S_REM    = 8'b0010_0000,
        S_FIX    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   conv_hi_reg, conv_hi_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    always_comb
    begin
        state_next   = state_reg;
        conv_hi_next = conv_hi_reg;
        out_free     = !valid_reg || !result_stall;
        cmd          = '0;
        cmd.conv_hi  = conv_hi_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.base_hit)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (status.done_next)
                begin
                    conv_hi_next = 1'b0;
                    state_next   = S_MUL;
                end
                else
                    state_next = S_EMIT;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.load_idle = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EST;
            end
            S_EST:
            begin
                cmd.est    = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (status.fix_ok)
                begin
                    cmd.store_mv = 1'b1;
                    if (conv_hi_reg)
                        state_next = S_EMIT;
                    else
                    begin
                        conv_hi_next = 1'b1;
                        state_next   = S_MUL;
                    end
                end
                else
                    cmd.fix = 1'b1;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.load_out)
            valid_next = 1'b1;
        else
            valid_next = valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            conv_hi_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            conv_hi_reg <= conv_hi_next;
            valid_reg   <= valid_next;
        end
    end

    assign sample_stall = state_reg != S_IDLE;
    assign result_valid = valid_reg;

endmodule

// File: src/sensor_min_max_calibrator.sv
// ----------------------------------------------------------------------------
// sensor_min_max_calibrator
// idle-level averaging, touch detection and min/max calibration window over
// converter samples, one result beat per sample beat
// per sample beat: the baseline, wait and window phases update and hand off
//   the result; the beat that closes the baseline also runs the 24 steps of
//   the bit-serial idle divider; once done, each beat adds two multiply /
//   reciprocal estimate / correction passes for the millivolts
// throughput: one sample beat at a time, a new beat is taken as soon as the
//   previous result sits in the output register
// reset: async active low, calibration restarts in the baseline phase and
//   configuration returns to its defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_min_max_calibrator #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [smmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smmc_pkg::CFG_W-1:0]      cfg_data,
    // sample channel
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [smmc_pkg::DATA_W-1:0]     sample,
    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [smmc_pkg::PHASE_W-1:0]    phase,
    output logic [smmc_pkg::DATA_W-1:0]     idle_level,
    output logic [smmc_pkg::DATA_W-1:0]     low_value,
    output logic [smmc_pkg::DATA_W-1:0]     high_value,
    output logic [smmc_pkg::DATA_W-1:0]     value_range,
    output logic [smmc_pkg::DATA_W-1:0]     low_millivolts,
    output logic [smmc_pkg::DATA_W-1:0]     high_millivolts,
    output logic                            done_res
);
    import smmc_pkg::*;

    // command / status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: takes one sample beat, walks it through the update, the
    // idle division when the baseline closes, the millivolt conversion
    // once the window has ended, and hands it to the output register
    smmc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath: config registers, phase / baseline / window state, the
    // shared conversion registers and the result beat registers
    smmc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample          (sample),
        .cmd             (cmd),
        .status          (status),
        .phase           (phase),
        .idle_level      (idle_level),
        .low_value       (low_value),
        .high_value      (high_value),
        .value_range     (value_range),
        .low_millivolts  (low_millivolts),
        .high_millivolts (high_millivolts),
        .done_res        (done_res)
    );

endmodule

// File: sim/sensor_min_max_calibrator_test.sv
// ----------------------------------------------------------------------------
// sensor_min_max_calibrator_test
// self-checking bench for the calibrator: walks one full calibration after
// reset (idle averaging, touch wait, min/max window, done) with register
// changes between bursts, predicts every result beat in its own model of
// the block or as a literal beat, and compares each whole beat as it comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_min_max_calibrator_test;

    import smmc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_ROWS   = 14;
    localparam int REPORT_MAX  = 10;
    localparam int SETTLE_CYC  = 40;

    // one expected or observed result beat
    typedef struct packed {
        phase_t            phase;
        logic [DATA_W-1:0] idle_level;
        logic [DATA_W-1:0] low_value;
        logic [DATA_W-1:0] high_value;
        logic [DATA_W-1:0] value_range;
        logic [DATA_W-1:0] low_millivolts;
        logic [DATA_W-1:0] high_millivolts;
        logic              done_res;
    } cal_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // one line of the directed plan
    typedef struct packed {
        row_kind_t         kind;
        cfg_idx_t          index;
        logic [CFG_W-1:0]  value;
        logic              typed;
    } plan_row_t;

    // clock, reset and block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic [DATA_W-1:0]    sample = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [PHASE_W-1:0]   phase;
    logic [DATA_W-1:0]    idle_level;
    logic [DATA_W-1:0]    low_value;
    logic [DATA_W-1:0]    high_value;
    logic [DATA_W-1:0]    value_range;
    logic [DATA_W-1:0]    low_millivolts;
    logic [DATA_W-1:0]    high_millivolts;
    logic                 done_res;

    // register mirrors
    logic [BASE_CNT_W-1:0] reg_base_count;
    logic [DATA_W-1:0]     reg_touch_thr;
    logic [WIN_CNT_W-1:0]  reg_window;
    logic [DATA_W-1:0]     reg_full_scale;

    // calibration state as the block should hold it
    phase_t                cal_phase;
    logic [BASE_SUM_W-1:0] base_sum;
    logic [BASE_CNT_W-1:0] base_cnt;
    logic [DATA_W-1:0]     idle_q;
    logic [DATA_W-1:0]     low_q;
    logic [DATA_W-1:0]     high_q;
    logic [WIN_CNT_W-1:0]  win_cnt;

    cal_result_t pending_results[$];
    cal_result_t reset_view;
    cal_result_t got_beat;
    cal_result_t want_beat;
    plan_row_t   plan [PLAN_ROWS];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    int  touch_thr_pick;
    int  boundary;
    logic [DATA_W-1:0] win_center;

    sensor_min_max_calibrator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .phase           (phase),
        .idle_level      (idle_level),
        .low_value       (low_value),
        .high_value      (high_value),
        .value_range     (value_range),
        .low_millivolts  (low_millivolts),
        .high_millivolts (high_millivolts),
        .done_res        (done_res)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // counts to millivolts, floored, against the current full scale
    function automatic logic [DATA_W-1:0] counts_to_mv(input logic [DATA_W-1:0] counts);
        logic [PROD_W-1:0] prod;
        prod = {{DATA_W{1'b0}}, counts} * {{DATA_W{1'b0}}, reg_full_scale};
        prod = prod / {{DATA_W{1'b0}}, SAT_MAX};
        return prod[DATA_W-1:0];
    endfunction

    // advances the calibration by one sample beat and returns the result beat
    function automatic cal_result_t calibrate_sample(input logic [DATA_W-1:0] s);
        cal_result_t           r;
        logic [BASE_DIV_W-1:0] divisor;
        logic [BASE_SUM_W-1:0] quot;
        logic [DATA_W-1:0]     offset;
        case (cal_phase)
            PH_BASELINE:
            begin
                base_sum = base_sum + {{(BASE_SUM_W-DATA_W){1'b0}}, s};
                base_cnt = base_cnt + 1'b1;
                if (base_cnt == reg_base_count)
                begin
                    // a wrapped counter stands for 256 samples
                    divisor = (base_cnt == '0) ? BASE_DIV_W'(256) : {1'b0, base_cnt};
                    quot = base_sum / {{(BASE_SUM_W-BASE_DIV_W){1'b0}}, divisor};
                    idle_q = (quot > {{(BASE_SUM_W-DATA_W){1'b0}}, SAT_MAX}) ?
                             SAT_MAX : quot[DATA_W-1:0];
                    cal_phase = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                offset = (s >= idle_q) ? (s - idle_q) : (idle_q - s);
                // the touching sample itself is not tracked
                if (offset >= reg_touch_thr)
                    cal_phase = PH_CAL;
            end
            PH_CAL:
            begin
                if (s < low_q)
                    low_q = s;
                if (s > high_q)
                    high_q = s;
                win_cnt = win_cnt + 1'b1;
                if (win_cnt == reg_window)
                    cal_phase = PH_DONE;
            end
            default:
            begin
                // done: samples are ignored
            end
        endcase
        r.phase      = cal_phase;
        r.idle_level = idle_q;
        r.low_value  = low_q;
        r.high_value = high_q;
        r.done_res   = (cal_phase == PH_DONE);
        r.value_range     = r.done_res ? (high_q - low_q) : '0;
        r.low_millivolts  = r.done_res ? counts_to_mv(low_q) : '0;
        r.high_millivolts = r.done_res ? counts_to_mv(high_q) : '0;
        return r;
    endfunction

    function automatic string show(input cal_result_t r);
        return $sformatf("phase=%0d idle=%0d low=%0d high=%0d range=%0d mv=%0d/%0d done=%0b",
                         r.phase, r.idle_level, r.low_value, r.high_value, r.value_range,
                         r.low_millivolts, r.high_millivolts, r.done_res);
    endfunction

    // random sample around a center, now and then a full-scale extreme when enabled
    function automatic logic [DATA_W-1:0] pick_sample(input logic [DATA_W-1:0] center,
                                                      input int span, input bit extremes);
        int v;
        if (extremes && $urandom_range(15) == 0)
            return $urandom_range(1) ? SAT_MAX : '0;
        v = int'(center) + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > int'(SAT_MAX))
            v = int'(SAT_MAX);
        return v[DATA_W-1:0];
    endfunction

    function automatic plan_row_t make_row(input row_kind_t kind, input cfg_idx_t index,
                                           input logic [CFG_W-1:0] value, input logic typed);
        plan_row_t row;
        row.kind  = kind;
        row.index = index;
        row.value = value;
        row.typed = typed;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // one sample beat, with an optional gap ahead of it; valid holds until taken
    task automatic send_sample(input logic [DATA_W-1:0] value);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 8)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_results.push_back(calibrate_sample(value));
    endtask

    // lets every outstanding result beat drain so the block is idle
    task automatic wait_for_results;
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_BASE_COUNT: reg_base_count = value[BASE_CNT_W-1:0];
            CFG_TOUCH_THR:  reg_touch_thr  = value;
            CFG_WINDOW:     reg_window     = value[WIN_CNT_W-1:0];
            default:        reg_full_scale = value;
        endcase
    endtask

    // window samples with a given spread around the window center
    task automatic run_window(input int count, input int span);
        repeat (count)
        begin
            if (cal_phase == PH_CAL)
                send_sample(pick_sample(win_center, span, 1'b1));
        end
    endtask

    // beats after the end, only the millivolts may move
    task automatic run_after_done(input int count);
        repeat (count)
            send_sample(pick_sample(16'h8000, 32768, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, check every accepted beat
    // ------------------------------------------------------------------

    always @(posedge clk)
        result_stall <= rst_n && !no_idle && ($urandom_range(99) < 8);

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            got_beat.phase           = phase_t'(phase);
            got_beat.idle_level      = idle_level;
            got_beat.low_value       = low_value;
            got_beat.high_value      = high_value;
            got_beat.value_range     = value_range;
            got_beat.low_millivolts  = low_millivolts;
            got_beat.high_millivolts = high_millivolts;
            got_beat.done_res        = done_res;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result beat: %s", show(got_beat));
            end
            else
            begin
                want_beat = pending_results.pop_front();
                if (got_beat !== want_beat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("mismatch %0d expected: %s", mismatch_count, show(want_beat));
                        $display("mismatch %0d actual:   %s", mismatch_count, show(got_beat));
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin
        // defaults as after reset
        reg_base_count = BASE_COUNT_RST;
        reg_touch_thr  = TOUCH_THR_RST;
        reg_window     = WINDOW_RST;
        reg_full_scale = FULL_SCALE_RST;
        cal_phase      = PH_BASELINE;
        base_sum       = '0;
        base_cnt       = '0;
        idle_q         = '0;
        low_q          = SAT_MAX;
        high_q         = '0;
        win_cnt        = '0;

        // what every beat of the idle averaging shows
        reset_view.phase           = PH_BASELINE;
        reset_view.idle_level      = '0;
        reset_view.low_value       = SAT_MAX;
        reset_view.high_value      = '0;
        reset_view.value_range     = '0;
        reset_view.low_millivolts  = '0;
        reset_view.high_millivolts = '0;
        reset_view.done_res        = 1'b0;

        // directed plan: extremes and alternating bit patterns while averaging,
        // the averaging count moved to its top and then to zero mid-phase
        plan[0]  = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'h0000, 1'b1);
        plan[1]  = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'hFFFF, 1'b1);
        plan[2]  = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'h8000, 1'b1);
        plan[3]  = make_row(ROW_WRITE,  CFG_BASE_COUNT, 16'd255,  1'b0);
        plan[4]  = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'h7FFF, 1'b1);
        plan[5]  = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'h5555, 1'b1);
        plan[6]  = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'hAAAA, 1'b0);
        plan[7]  = make_row(ROW_WRITE,  CFG_FULL_SCALE, 16'd0,    1'b0);
        plan[8]  = make_row(ROW_WRITE,  CFG_TOUCH_THR,  16'd0,    1'b0);
        plan[9]  = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'h0001, 1'b0);
        plan[10] = make_row(ROW_WRITE,  CFG_BASE_COUNT, 16'd0,    1'b0);
        plan[11] = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'hFFFE, 1'b0);
        plan[12] = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'h00FF, 1'b0);
        plan[13] = make_row(ROW_SAMPLE, CFG_BASE_COUNT, 16'hFF00, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                wait_for_results;
                write_reg(plan[i].index, plan[i].value);
            end
            else
            begin
                send_sample(plan[i].value);
                // typed rows replace the predicted beat with the literal one
                if (plan[i].typed)
                begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(reset_view);
                end
            end
        end

        // rest of the averaging: count is zero, so it closes when the counter wraps
        while (cal_phase == PH_BASELINE)
            send_sample(pick_sample(16'h8000, 32768, 1'b1));

        // touch wait with an unreachable threshold, full-range noise
        wait_for_results;
        write_reg(CFG_TOUCH_THR, SAT_MAX);
        repeat (12)
        begin
            if (cal_phase == PH_WAIT)
                send_sample(pick_sample(idle_q, 32768, 1'b1));
        end

        // realistic threshold, noise that stays just inside it
        wait_for_results;
        touch_thr_pick = $urandom_range(9000, 3000);
        write_reg(CFG_TOUCH_THR, touch_thr_pick[CFG_W-1:0]);
        for (int n = 0; n < 40 && cal_phase == PH_WAIT; n++)
            send_sample(pick_sample(idle_q, touch_thr_pick - 1, 1'b0));

        // one count short of a touch
        if (cal_phase == PH_WAIT)
        begin
            boundary = int'(idle_q) + touch_thr_pick - 1;
            if (boundary > int'(SAT_MAX))
                boundary = int'(idle_q) - touch_thr_pick + 1;
            if (boundary >= 0)
                send_sample(boundary[DATA_W-1:0]);
        end

        // zero threshold: even a sample at the idle level opens the window
        wait_for_results;
        write_reg(CFG_TOUCH_THR, '0);
        while (cal_phase == PH_WAIT)
            send_sample(idle_q);

        // calibration window, spread widening so min and max keep moving;
        // the window length moves under the running counter
        win_center = DATA_W'($urandom_range(49151, 16384));
        run_window(300, 2000);
        wait_for_results;
        write_reg(CFG_WINDOW, 16'd1);
        run_window(300, 8000);
        wait_for_results;
        // zero length: the default end point passes without closing
        write_reg(CFG_WINDOW, '0);
        no_idle = 1'b1;
        run_window(300, 20000);
        wait_for_results;
        no_idle = 1'b0;
        write_reg(CFG_WINDOW, SAT_MAX);
        run_window(300, 32768);
        wait_for_results;
        write_reg(CFG_WINDOW, win_cnt + 16'd250);
        while (cal_phase == PH_CAL)
            send_sample(pick_sample(win_center, 32768, 1'b1));

        // after the end, the result repeats; full scale still steers millivolts
        run_after_done(6);
        wait_for_results;
        write_reg(CFG_FULL_SCALE, '0);
        run_after_done(6);
        wait_for_results;
        write_reg(CFG_FULL_SCALE, SAT_MAX);
        write_reg(CFG_BASE_COUNT, 16'd1);
        run_after_done(6);
        wait_for_results;
        write_reg(CFG_FULL_SCALE, 16'd1);
        write_reg(CFG_TOUCH_THR, SAT_MAX);
        write_reg(CFG_WINDOW, 16'd1);
        run_after_done(6);
        wait_for_results;
        write_reg(CFG_FULL_SCALE, CFG_W'($urandom));
        run_after_done(6);

        // drain, then give the block time for anything stray
        wait_for_results;
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
src/smmc_pkg.sv
src/smmc_divider.sv
src/smmc_datapath.sv
src/smmc_ctrl.sv
src/sensor_min_max_calibrator.sv
sim/sensor_min_max_calibrator_test.sv
